// ===== hw/rtl/mcn_pkg.sv =====
// Package for the matrix column normaliser: fixed datapath widths, pipeline
// stage counts and the stage record types shared by the stage modules.
// No dependencies.
`default_nettype none
package mcn_pkg;

   localparam int MAG_W       = 32;             // internal magnitude width
   localparam int SUM_W       = 2 * MAG_W;      // sum of squares width
   localparam int REM_W       = MAG_W + 3;      // square root remainder width
   localparam int STEPS       = 2;              // iterations per pipeline stage
   localparam int SQRT_STAGES = MAG_W / STEPS;  // square root pipeline stages
   localparam int DIV_STAGES  = MAG_W / STEPS;  // divider pipeline stages
   localparam int LANES       = 3;
   localparam logic [MAG_W-1:0] Q30_ONE = MAG_W'(1) << 30;

   typedef struct packed {
      logic [LANES-1:0]            neg;
      logic [LANES-1:0][MAG_W-1:0] mag;
   } side_type;

   typedef struct packed {
      logic             valid;
      logic [REM_W-1:0] rem;
      logic [MAG_W-1:0] root;
      logic [SUM_W-1:0] v;
      side_type         side;
   } sqrt_type;

   typedef struct packed {
      logic                        valid;
      logic [LANES-1:0][MAG_W-1:0] r;
      logic [LANES-1:0][MAG_W-1:0] d;
      logic [LANES-1:0][MAG_W-1:0] q;
      logic [MAG_W-1:0]            len;
      logic [LANES-1:0]            neg;
   } div_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mcn_sqrt_stage.sv =====
// One registered stage of the pipelined square root: two root bits a stage.
// Depends on mcn_pkg.
`default_nettype none
module mcn_sqrt_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mcn_pkg::sqrt_type stage_in,
   output mcn_pkg::sqrt_type     stage_out
);
   mcn_pkg::sqrt_type stage_ff;
   mcn_pkg::sqrt_type stage_in_w;
   logic [mcn_pkg::REM_W-1:0] trial;
   logic [mcn_pkg::REM_W-1:0] shifted;

   always_comb begin
      stage_in_w = stage_in;
      trial      = '0;
      shifted    = '0;
      for (int k = 0; k < mcn_pkg::STEPS; k++) begin
         shifted = {stage_in_w.rem[mcn_pkg::REM_W-3:0],
                    stage_in_w.v[mcn_pkg::SUM_W-1 -: 2]};
         trial   = mcn_pkg::REM_W'({stage_in_w.root, 2'b01});
         stage_in_w.v = stage_in_w.v << 2;
         if (shifted >= trial) begin
            stage_in_w.rem  = shifted - trial;
            stage_in_w.root = {stage_in_w.root[mcn_pkg::MAG_W-2:0], 1'b1};
         end else begin
            stage_in_w.rem  = shifted;
            stage_in_w.root = {stage_in_w.root[mcn_pkg::MAG_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/mcn_div_stage.sv =====
// One registered stage of the three-lane restoring divider: two quotient
// bits a stage in each lane. Depends on mcn_pkg.
`default_nettype none
module mcn_div_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire mcn_pkg::div_type stage_in,
   output mcn_pkg::div_type     stage_out
);
   mcn_pkg::div_type stage_ff;
   mcn_pkg::div_type stage_in_w;
   logic [mcn_pkg::MAG_W:0] trial;

   always_comb begin
      stage_in_w = stage_in;
      trial      = '0;
      for (int l = 0; l < mcn_pkg::LANES; l++) begin
         for (int k = 0; k < mcn_pkg::STEPS; k++) begin
            trial = {stage_in_w.r[l], stage_in_w.d[l][mcn_pkg::MAG_W-1]};
            stage_in_w.d[l] = stage_in_w.d[l] << 1;
            if (trial >= {1'b0, stage_in_w.len}) begin
               stage_in_w.r[l] = mcn_pkg::MAG_W'(trial - {1'b0, stage_in_w.len});
               stage_in_w.q[l] = {stage_in_w.q[l][mcn_pkg::MAG_W-2:0], 1'b1};
            end else begin
               stage_in_w.r[l] = trial[mcn_pkg::MAG_W-1:0];
               stage_in_w.q[l] = {stage_in_w.q[l][mcn_pkg::MAG_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/matrix_column_normalize.sv =====
// Top level of the matrix column normaliser: input split, squaring, the
// square root and divider pipelines, and the result register.
// Depends on mcn_pkg, mcn_sqrt_stage and mcn_div_stage.
//
// Usage. The block takes one basis column (x, y, z) of a transform in signed
// Q16.16 and returns its Euclidean length in unsigned Q16.16 together with
// the column scaled to unit length in signed Q1.30. A zero column gives a
// zero unit vector and raises rsp_zero_length.
// A transfer in is taken at each rising edge with start high; busy is never
// raised, so a new column may be offered in every cycle.
// Each result appears for exactly one cycle with rsp_valid high, after its
// column has passed the split, square and sum registers, the square root
// stages (two root bits a stage), the stages of the three parallel
// dividers (two quotient bits a stage) and the result register. Results
// leave in the order columns arrived.
// Throughput is one column per cycle; the pipeline has no stall path because
// the receiver cannot hold results off.
// A synchronous reset clears every stage valid bit, so items in flight are
// dropped and no result is produced until new columns arrive.
// Only the low min(DATA_WIDTH, 32) bits of each input are used.
`default_nettype none
module matrix_column_normalize #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [DATA_WIDTH-1:0] req_col_x,
   input  wire logic signed [DATA_WIDTH-1:0] req_col_y,
   input  wire logic signed [DATA_WIDTH-1:0] req_col_z,
   output logic                              rsp_valid,
   output logic [DATA_WIDTH-1:0]             rsp_axis_scale,
   output logic signed [31:0]                rsp_unit_x,
   output logic signed [31:0]                rsp_unit_y,
   output logic signed [31:0]                rsp_unit_z,
   output logic                              rsp_zero_length
);
   localparam int EW      = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
   localparam int LATENCY = 3 + mcn_pkg::SQRT_STAGES + mcn_pkg::DIV_STAGES + 1;
   localparam int MW      = mcn_pkg::MAG_W;

   // Split stage: sign and magnitude of each component.
   logic [mcn_pkg::LANES-1:0][EW-1:0] raw_w;
   mcn_pkg::side_type split_in, split_ff, sq_side_ff;
   logic split_valid_ff, sq_valid_ff;
   logic [mcn_pkg::LANES-1:0][mcn_pkg::SUM_W-1:0] sq_ff;
   logic [EW-1:0] mag_w;

   assign busy = 1'b0;

   always_comb begin
      raw_w[0] = req_col_x[EW-1:0];
      raw_w[1] = req_col_y[EW-1:0];
      raw_w[2] = req_col_z[EW-1:0];
      split_in = '0;
      mag_w    = '0;
      for (int l = 0; l < mcn_pkg::LANES; l++) begin
         // Two's complement negation also gives the right magnitude for the
         // most negative value when read as unsigned.
         split_in.neg[l] = raw_w[l][EW-1];
         mag_w           = raw_w[l][EW-1] ? (~raw_w[l] + 1'b1) : raw_w[l];
         split_in.mag[l] = MW'(mag_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_valid_ff <= 1'b0;
         sq_valid_ff    <= 1'b0;
      end else begin
         split_valid_ff <= start;
         sq_valid_ff    <= split_valid_ff;
      end
   end

   // Payload registers of the split and squaring stages.
   always_ff @(posedge clock) begin
      split_ff   <= split_in;
      sq_side_ff <= split_ff;
      for (int l = 0; l < mcn_pkg::LANES; l++) begin
         sq_ff[l] <= split_ff.mag[l] * split_ff.mag[l];
      end
   end

   // Sum stage feeds the square root pipeline. Three squares of at most
   // 2^62 each cannot overflow 64 bits.
   mcn_pkg::sqrt_type sqrt_chain [mcn_pkg::SQRT_STAGES+1];
   mcn_pkg::sqrt_type sum_in;

   always_comb begin
      sum_in       = '0;
      sum_in.valid = sq_valid_ff;
      sum_in.v     = sq_ff[0] + sq_ff[1] + sq_ff[2];
      sum_in.side  = sq_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqrt_chain[0].valid <= 1'b0;
      end else begin
         sqrt_chain[0] <= sum_in;
      end
   end

   for (genvar s = 0; s < mcn_pkg::SQRT_STAGES; s++) begin : g_sqrt
      mcn_sqrt_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (sqrt_chain[s]),
         .stage_out (sqrt_chain[s+1])
      );
   end

   // Divider set-up: the length is never below any component magnitude, so
   // the first partial remainder (magnitude shifted down by two) is already
   // below the divisor and the quotient of mag * 2^30 fits in 32 bits.
   mcn_pkg::div_type div_chain [mcn_pkg::DIV_STAGES+1];
   mcn_pkg::sqrt_type sqrt_last;

   assign sqrt_last = sqrt_chain[mcn_pkg::SQRT_STAGES];

   always_comb begin
      div_chain[0]       = '0;
      div_chain[0].valid = sqrt_last.valid;
      div_chain[0].len   = sqrt_last.root;
      div_chain[0].neg   = sqrt_last.side.neg;
      for (int l = 0; l < mcn_pkg::LANES; l++) begin
         div_chain[0].r[l] = sqrt_last.side.mag[l] >> 2;
         div_chain[0].d[l] = {sqrt_last.side.mag[l][1:0], {(MW-2){1'b0}}};
      end
   end

   for (genvar s = 0; s < mcn_pkg::DIV_STAGES; s++) begin : g_div
      mcn_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (div_chain[s]),
         .stage_out (div_chain[s+1])
      );
   end

   // Result stage: saturate to one, apply signs, force zeros for a zero
   // length (the divider output is meaningless then).
   mcn_pkg::div_type div_last;
   logic [mcn_pkg::LANES-1:0][MW-1:0] unit_in;
   logic [MW-1:0] q_sat;
   logic zero_in;
   logic valid_ff;
   logic [DATA_WIDTH-1:0] axis_ff;
   logic [mcn_pkg::LANES-1:0][MW-1:0] unit_ff;
   logic zero_ff;

   assign div_last = div_chain[mcn_pkg::DIV_STAGES];
   assign zero_in  = (div_last.len == '0);

   always_comb begin
      unit_in = '0;
      q_sat   = '0;
      for (int l = 0; l < mcn_pkg::LANES; l++) begin
         q_sat = (div_last.q[l] > mcn_pkg::Q30_ONE) ? mcn_pkg::Q30_ONE : div_last.q[l];
         if (zero_in) begin
            unit_in[l] = '0;
         end else begin
            unit_in[l] = div_last.neg[l] ? (~q_sat + 1'b1) : q_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= div_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff <= DATA_WIDTH'(div_last.len);
      unit_ff <= unit_in;
      zero_ff <= zero_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_axis_scale  = axis_ff;
   assign rsp_unit_x      = unit_ff[0];
   assign rsp_unit_y      = unit_ff[1];
   assign rsp_unit_z      = unit_ff[2];
   assign rsp_zero_length = zero_ff;

   // A result only ever follows an accepted column by the pipeline latency.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching transfer in");

   // A zero length always comes with a zero unit vector.
   a_zero_unit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_length) |->
         (rsp_unit_x == 0 && rsp_unit_y == 0 && rsp_unit_z == 0))
      else $error("zero length with non-zero unit vector");

   // Unit components never exceed plus or minus one in Q1.30.
   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_x <= 32'sh4000_0000 && rsp_unit_x >= -32'sh4000_0000 &&
                     rsp_unit_y <= 32'sh4000_0000 && rsp_unit_y >= -32'sh4000_0000 &&
                     rsp_unit_z <= 32'sh4000_0000 && rsp_unit_z >= -32'sh4000_0000))
      else $error("unit component outside plus or minus one");

endmodule
`default_nettype wire
